>>> src/fcds_pkg.sv
// Shared types and constants for the four-channel DMA service step.
`timescale 1ns / 1ps

package fcds_pkg;

   // Default sizing
   localparam int NumChannelsDefault = 4;
   localparam int AddressBitsDefault = 24;

   // Fixed field widths
   localparam int OpW      = 2;
   localparam int ChanW    = 2;
   localparam int AddrW    = 24;
   localparam int CountW   = 16;
   localparam int MaskW    = 4;
   localparam int KindW    = 2;
   localparam int ModeW    = 8;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 8;
   localparam int LowStepW = 16;

   // Operations
   localparam logic [OpW-1:0] OpTick       = 2'd0;
   localparam logic [OpW-1:0] OpLoad       = 2'd1;
   localparam logic [OpW-1:0] OpWriteMask  = 2'd2;
   localparam logic [OpW-1:0] OpClearStat  = 2'd3;

   // Register indexes
   localparam logic [CsrIdxW-1:0] CsrModeLast = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrWrapLow  = 3'd4;
   localparam int NumModeRegs = 4;

   // Mode byte fields
   localparam logic [ModeW-1:0] ModeKindField = 8'h0c;
   localparam logic [ModeW-1:0] ModeKindP2M   = 8'h04;
   localparam logic [ModeW-1:0] ModeDirDown   = 8'h20;

   // Transfer kinds
   localparam logic [KindW-1:0] KindVerify = 2'd0;
   localparam logic [KindW-1:0] KindP2M    = 2'd1;
   localparam logic [KindW-1:0] KindM2P    = 2'd2;

   typedef struct packed {
      logic [OpW-1:0]    operation;
      logic [ChanW-1:0]  channel;
      logic [AddrW-1:0]  start_address;
      logic [CountW-1:0] transfer_count;
      logic [MaskW-1:0]  enable_mask;
      logic [MaskW-1:0]  hold_mask;
   } req_type;

   typedef struct packed {
      logic [ChanW-1:0] served_channel;
      logic [KindW-1:0] transfer_kind;
      logic [AddrW-1:0] memory_address;
      logic             terminal_count;
      logic [MaskW-1:0] status_bits;
      logic             last_transfer;
   } rsp_type;

endpackage

>>> src/four_channel_dma_service_step.sv
// Top level: DMA channel state, sequencer serving one channel per unstalled cycle.
//
//  port group   dir   handshake                     payload
//  req_*        in    req_valid / req_ready         req_data   (fcds_pkg::req_type)
//  rsp_*        out   rsp_valid / rsp_ready         rsp_data   (fcds_pkg::rsp_type)
//  csr_*        in    csr_write_enable, no wait     csr_index, csr_write_data
//
// Load, mask-write and clear-status requests produce nothing.
// A tick services each pending channel (up to 4), one transfer each, through
// the single count/address step unit that visits the channels in order.
// A full output register that is not taken stalls the sequencer.
// Reset is synchronous and clears all channel state; no clearing pass is needed.
`timescale 1ns / 1ps

module four_channel_dma_service_step #(
   parameter int NUM_CHANNELS = fcds_pkg::NumChannelsDefault,
   parameter int ADDRESS_BITS = fcds_pkg::AddressBitsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fcds_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fcds_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write_enable,
   input  logic [fcds_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [fcds_pkg::CsrDataW-1:0]     csr_write_data
);
   import fcds_pkg::*;

   localparam int ChanIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam logic StIdle  = 1'b0;
   localparam logic StServe = 1'b1;

   logic state_ff, state_in;
   logic [NUM_CHANNELS-1:0] pend_ff, pend_in;
   logic [NUM_CHANNELS-1:0] working_ff, working_in;
   logic [NUM_CHANNELS-1:0] done_ff, done_in;
   logic [ADDRESS_BITS-1:0] addr_ff [NUM_CHANNELS];
   logic [ADDRESS_BITS-1:0] addr_in [NUM_CHANNELS];
   logic [CountW-1:0]       count_ff [NUM_CHANNELS];
   logic [CountW-1:0]       count_in [NUM_CHANNELS];
   logic [ModeW-1:0]        mode_ff [NUM_CHANNELS];
   logic [ModeW-1:0]        mode_in [NUM_CHANNELS];
   logic                    wrap_ff, wrap_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    req_fire;
   logic                    emit;
   logic [ChanIdxW-1:0]     sel;
   logic [NUM_CHANNELS-1:0] sel_bit;
   logic [ADDRESS_BITS-1:0] cur_addr;
   logic [CountW-1:0]       cur_count;
   logic [ModeW-1:0]        cur_mode;
   logic                    step_down;
   logic [ADDRESS_BITS-1:0] step_full;
   logic [LowStepW-1:0]     step_low;
   logic [ADDRESS_BITS-1:0] next_addr;
   logic                    tc;
   logic [KindW-1:0]        kind;

   assign req_ready = (state_ff == StIdle);
   assign req_fire  = req_valid && req_ready;
   assign emit      = (state_ff == StServe) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // lowest pending channel goes next
   always_comb begin
      sel = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel = ChanIdxW'(i);
         end
      end
   end

   assign sel_bit   = NUM_CHANNELS'(1) << sel;
   assign cur_addr  = addr_ff[sel];
   assign cur_count = count_ff[sel];
   assign cur_mode  = mode_ff[sel];
   assign step_down = (cur_mode & ModeDirDown) != '0;
   assign tc        = (cur_count == '0);

   // shared step unit: full-width or low-16 address step
   assign step_full = step_down ? cur_addr - ADDRESS_BITS'(1) : cur_addr + ADDRESS_BITS'(1);
   assign step_low  = step_down ? LowStepW'(cur_addr) - LowStepW'(1)
                                : LowStepW'(cur_addr) + LowStepW'(1);
   assign next_addr = wrap_ff ? ((cur_addr & ~ADDRESS_BITS'(17'h0ffff)) | ADDRESS_BITS'(step_low))
                              : step_full;

   always_comb begin
      if ((cur_mode & ModeKindField) == '0) begin
         kind = KindVerify;
      end else if ((cur_mode & ModeKindField) == ModeKindP2M) begin
         kind = KindP2M;
      end else begin
         kind = KindM2P;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      working_in   = working_ff;
      done_in      = done_ff;
      addr_in      = addr_ff;
      count_in     = count_ff;
      mode_in      = mode_ff;
      wrap_in      = wrap_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_write_enable) begin
         if (csr_index <= CsrModeLast) begin
            if (int'(csr_index) < NUM_CHANNELS && int'(csr_index) < NumModeRegs) begin
               mode_in[ChanIdxW'(csr_index)] = csr_write_data;
            end
         end else if (csr_index == CsrWrapLow) begin
            wrap_in = csr_write_data[0];
         end
      end

      if (req_fire) begin
         case (req_data.operation)
            OpTick: begin
               pend_in = working_ff & ~NUM_CHANNELS'(req_data.hold_mask);
               if (pend_in != '0) begin
                  state_in = StServe;
               end
            end
            OpLoad: begin
               if (int'(req_data.channel) < NUM_CHANNELS) begin
                  addr_in[ChanIdxW'(req_data.channel)]  = ADDRESS_BITS'(req_data.start_address);
                  count_in[ChanIdxW'(req_data.channel)] = req_data.transfer_count;
               end
            end
            OpWriteMask: begin
               working_in = NUM_CHANNELS'(req_data.enable_mask);
            end
            OpClearStat: begin
               done_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (emit) begin
         if (tc) begin
            done_in    = done_ff | sel_bit;
            working_in = working_ff & ~sel_bit;
         end
         count_in[sel] = cur_count - CountW'(1);
         addr_in[sel]  = next_addr;
         pend_in       = pend_ff & ~sel_bit;
         if (pend_in == '0) begin
            state_in = StIdle;
         end
         rsp_valid_in               = 1'b1;
         rsp_data_in.served_channel = ChanW'(sel);
         rsp_data_in.transfer_kind  = kind;
         rsp_data_in.memory_address = AddrW'(cur_addr);
         rsp_data_in.terminal_count = tc;
         rsp_data_in.status_bits    = MaskW'(done_in);
         rsp_data_in.last_transfer  = (pend_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         pend_ff      <= '0;
         working_ff   <= '0;
         done_ff      <= '0;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            addr_ff[i]  <= '0;
            count_ff[i] <= '0;
            mode_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         working_ff   <= working_in;
         done_ff      <= done_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
         addr_ff      <= addr_in;
         count_ff     <= count_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> tb/sv/dma_transfer_checker.sv
// Checker: tracks DMA channel state, predicts each transfer and compares it with the block.
`timescale 1ns / 1ps

module dma_transfer_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  fcds_pkg::req_type            req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  fcds_pkg::rsp_type            rsp_data,
   input  logic                         csr_write_enable,
   input  logic [fcds_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [fcds_pkg::CsrDataW-1:0] csr_write_data,
   output int                           error_count,
   output int                           pending_count
);
   import fcds_pkg::*;

   localparam int NumCh = NumChannelsDefault;

   logic [AddrW-1:0]  chan_addr  [NumCh];
   logic [CountW-1:0] chan_count [NumCh];
   logic [ModeW-1:0]  chan_mode  [NumCh];
   logic [MaskW-1:0]  working;
   logic [MaskW-1:0]  done;
   logic              wrap_low;
   rsp_type           expected_transfers [$];

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Applies one request to the channel state and queues the transfers it causes.
   task automatic advance_channels(input req_type r);
      logic [MaskW-1:0]    eligible;
      logic [AddrW-1:0]    a;
      logic [LowStepW-1:0] lo;
      logic                down;
      int                  last_ch;
      rsp_type             t;
      case (r.operation)
         OpLoad: begin
            chan_addr[r.channel]  = r.start_address;
            chan_count[r.channel] = r.transfer_count;
         end
         OpWriteMask: working = r.enable_mask;
         OpClearStat: done = '0;
         default: begin
            // serving a channel never changes who else is eligible this tick
            eligible = working & ~r.hold_mask;
            last_ch = -1;
            for (int i = 0; i < NumCh; i++)
               if (eligible[i]) last_ch = i;
            for (int i = 0; i < NumCh; i++) begin
               if (eligible[i]) begin
                  t = '0;
                  if (chan_count[i] == '0) begin
                     done[i]    = 1'b1;
                     working[i] = 1'b0;
                     t.terminal_count = 1'b1;
                  end
                  chan_count[i] = chan_count[i] - CountW'(1);
                  if ((chan_mode[i] & ModeKindField) == '0)
                     t.transfer_kind = KindVerify;
                  else if ((chan_mode[i] & ModeKindField) == ModeKindP2M)
                     t.transfer_kind = KindP2M;
                  else
                     t.transfer_kind = KindM2P;
                  a    = chan_addr[i];
                  down = (chan_mode[i] & ModeDirDown) != '0;
                  if (wrap_low) begin
                     lo = down ? a[LowStepW-1:0] - LowStepW'(1) : a[LowStepW-1:0] + LowStepW'(1);
                     chan_addr[i] = {a[AddrW-1:LowStepW], lo};
                  end else begin
                     chan_addr[i] = down ? a - AddrW'(1) : a + AddrW'(1);
                  end
                  t.served_channel = ChanW'(i);
                  t.memory_address = a;
                  t.status_bits    = done;
                  t.last_transfer  = (i == last_ch);
                  expected_transfers.push_back(t);
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NumCh; i++) begin
            chan_addr[i]  = '0;
            chan_count[i] = '0;
            chan_mode[i]  = '0;
         end
         working  = '0;
         done     = '0;
         wrap_low = 1'b0;
         expected_transfers.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index <= CsrModeLast)
               chan_mode[csr_index[ChanW-1:0]] = csr_write_data;
            else if (csr_index == CsrWrapLow)
               wrap_low = csr_write_data[0];
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_transfers.size() == 0) begin
               $error("transfer from channel %0d with none expected", rsp_data.served_channel);
               error_count++;
            end else begin
               want = expected_transfers.pop_front();
               check_field("served_channel", 32'(want.served_channel),
                           32'(rsp_data.served_channel));
               check_field("transfer_kind", 32'(want.transfer_kind),
                           32'(rsp_data.transfer_kind));
               check_field("memory_address", 32'(want.memory_address),
                           32'(rsp_data.memory_address));
               check_field("terminal_count", 32'(want.terminal_count),
                           32'(rsp_data.terminal_count));
               check_field("status_bits", 32'(want.status_bits),
                           32'(rsp_data.status_bits));
               check_field("last_transfer", 32'(want.last_transfer),
                           32'(rsp_data.last_transfer));
            end
         end
         if (req_valid && req_ready)
            advance_channels(req_data);
      end
      pending_count = expected_transfers.size();
   end

endmodule

>>> tb/sv/tb_four_channel_dma_service_step.sv
// Testbench top: clock, reset, request and register stimulus, and the verdict.
`timescale 1ns / 1ps

module tb_four_channel_dma_service_step;
   import fcds_pkg::*;

   localparam int SettleCycles = 12;
   localparam int PhaseItems   = 20;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   req_type             req_data         = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write_enable = 1'b0;
   logic [CsrIdxW-1:0]  csr_index        = '0;
   logic [CsrDataW-1:0] csr_write_data   = '0;
   int                  error_count;
   int                  pending_count;
   int                  send_idle_pct    = 0;
   int                  stall_pct        = 0;
   int                  sent             = 0;

   always #5 clock = ~clock;

   four_channel_dma_service_step u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   dma_transfer_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic req_type random_req();
      req_type r;
      r.operation      = OpW'($urandom);
      r.channel        = ChanW'($urandom);
      r.start_address  = AddrW'($urandom);
      r.transfer_count = CountW'($urandom);
      r.enable_mask    = MaskW'($urandom);
      r.hold_mask      = MaskW'($urandom);
      return r;
   endfunction

   function automatic logic [AddrW-1:0] pick_address();
      logic [AddrW-1:0] a;
      a = AddrW'($urandom);
      case ($urandom_range(3))
         0: a[LowStepW-1:0] = '1;
         1: a[LowStepW-1:0] = '0;
         2: a = {AddrW{1'($urandom_range(1))}};
         default: ;
      endcase
      return a;
   endfunction

   function automatic logic [CountW-1:0] pick_count();
      logic [CountW-1:0] c;
      case ($urandom_range(9))
         7, 8:    c = CountW'($urandom);
         9:       c = '1;
         default: c = CountW'($urandom_range(4));
      endcase
      return c;
   endfunction

   // Called at a rising edge; returns at the edge that accepts the request.
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_load(input logic [ChanW-1:0] ch, input logic [AddrW-1:0] addr,
                            input logic [CountW-1:0] cnt);
      req_type r;
      r = random_req();
      r.operation      = OpLoad;
      r.channel        = ch;
      r.start_address  = addr;
      r.transfer_count = cnt;
      send_request(r);
   endtask

   task automatic send_mask(input logic [MaskW-1:0] en);
      req_type r;
      r = random_req();
      r.operation   = OpWriteMask;
      r.enable_mask = en;
      send_request(r);
   endtask

   task automatic send_tick(input logic [MaskW-1:0] hold);
      req_type r;
      r = random_req();
      r.operation = OpTick;
      r.hold_mask = hold;
      send_request(r);
   endtask

   task automatic send_clear();
      req_type r;
      r = random_req();
      r.operation = OpClearStat;
      send_request(r);
   endtask

   // Wait until every predicted transfer is out, then let a silent tick finish.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // modes packs mode3..mode0; one out-of-range index is written too and must do nothing.
   task automatic configure(input logic [4*ModeW-1:0] modes, input logic wrap);
      logic [CsrDataW-1:0] data;
      for (int i = 0; i < NumModeRegs; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CsrIdxW'(i);
         csr_write_data   <= modes[i*ModeW +: ModeW];
         @(posedge clock);
      end
      data    = CsrDataW'($urandom);
      data[0] = wrap;
      csr_index      <= CsrWrapLow;
      csr_write_data <= data;
      @(posedge clock);
      csr_index      <= CsrWrapLow + CsrIdxW'(1 + $urandom_range(2));
      csr_write_data <= CsrDataW'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly load / enable / tick sequences with random content, some raw noise.
   task automatic run_traffic(input int items);
      int start;
      start = sent;
      while (sent - start < items) begin
         if ($urandom_range(99) < 15) begin
            send_request(random_req());
         end else begin
            for (int ch = 0; ch < NumChannelsDefault; ch++)
               if ($urandom_range(1) == 1) send_load(ChanW'(ch), pick_address(), pick_count());
            send_mask(MaskW'($urandom_range(1, 15)));
            repeat ($urandom_range(2, 6))
               send_tick($urandom_range(1) == 1 ? MaskW'(0) : MaskW'($urandom));
            if ($urandom_range(9) < 3) send_clear();
         end
      end
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // full 24-bit stepping: wrap up past the top, down past zero
      configure({8'hFF, 8'h28, 8'h04, 8'h00}, 1'b0);
      send_tick(4'h0);
      send_load(2'd0, 24'hFF_FFFF, 16'h0001);
      send_load(2'd1, 24'h00_0000, 16'h0000);
      send_load(2'd2, 24'h00_0000, 16'h0002);
      send_load(2'd3, 24'h80_0000, 16'hFFFF);
      send_mask(4'hF);
      send_tick(4'h0);
      send_tick(4'hA);
      send_tick(4'hF);
      send_clear();
      send_tick(4'h0);
      send_mask(4'h0);
      send_tick(4'h0);
      drain();

      // low-16 stepping keeps the upper address byte
      configure({8'h00, 8'h04, 8'h2C, 8'hFF}, 1'b1);
      send_load(2'd0, 24'h12_0000, 16'h0001);
      send_load(2'd1, 24'hFF_FFFF, 16'h0002);
      send_load(2'd2, 24'h34_FFFF, 16'h0000);
      send_load(2'd3, 24'hAB_FFFF, 16'h0001);
      send_mask(4'hF);
      send_tick(4'h0);
      send_tick(4'h0);
      send_tick(4'h5);
      send_clear();
      send_tick(4'h0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
               configure({8'hFF, 8'h28, 8'h04, 8'h00}, 1'b0);
            end
            1: begin
               send_idle_pct = 65;
               stall_pct     = 0;
               configure($urandom, 1'b1);
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 65;
               configure({4{8'hFF}}, 1'b0);
            end
            default: begin
               send_idle_pct = 23;
               stall_pct     = 23;
               configure({8'hD7, 8'h0C, 8'h00, 8'h24}, 1'b1);
            end
         endcase
         run_traffic(PhaseItems);
         drain();
      end

      if (error_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
